// ===== design/blvm_pkg.sv =====
// ----------------------------------------------------------------------------
// blvm_pkg: battery low voltage monitor shared types and constants
// Transaction structs, register indexes and fixed constants of the monitor.
// ----------------------------------------------------------------------------
package blvm_pkg;

  localparam int ADC_W  = 10;
  localparam int MV_W   = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 32;
  localparam int CIDX_W = 3;

  // two-cell pack detection level on the first sample
  localparam logic [MV_W-1:0] TWO_CELL_MV = 16'd5500;

  // register reset values
  localparam logic [15:0] GAIN_RST     = 16'd2560;
  localparam logic [15:0] LOW_ONE_RST  = 16'd3300;
  localparam logic [15:0] HIGH_ONE_RST = 16'd3500;
  localparam logic [15:0] LOW_TWO_RST  = 16'd6600;
  localparam logic [15:0] HIGH_TWO_RST = 16'd7000;
  localparam logic [15:0] LED_RST      = 16'd75;
  localparam logic [31:0] SHUT_RST     = 32'd30000;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SENSE_GAIN = 3'd0,
    CFG_LOW_ONE    = 3'd1,
    CFG_HIGH_ONE   = 3'd2,
    CFG_LOW_TWO    = 3'd3,
    CFG_HIGH_TWO   = 3'd4,
    CFG_LED_PERIOD = 3'd5,
    CFG_SHUTDOWN   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CELLS_UNKNOWN = 2'd0,
    CELLS_ONE     = 2'd1,
    CELLS_TWO     = 2'd2
  } cell_t;

  typedef struct packed {
    logic [ADC_W-1:0]  sample_adc;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic            undervolt;
    logic [MV_W-1:0] average_mv;
    logic            led_level;
    logic            power_down;
  } status_t;

endpackage

// ===== design/battery_low_voltage_monitor_top.sv =====
// ----------------------------------------------------------------------------
// battery_low_voltage_monitor_top: battery undervoltage detector
// Scales converter samples to millivolts, keeps a running ring average and
// flags a low battery with hysteresis; drives a warning LED and latches
// power-down after a long enough time without good power.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  sample   | sample_valid, sample_stall, sample      | in
//  status   | status_valid, status_stall, status      | out
//  config   | cfg_write, cfg_index, cfg_data          | in
//
//  One transaction per clock unless status stalls; one status per sample.
//  From acceptance a sample passes the input register, scale multiplier,
//  state update and average reciprocal multiplier into the output register.
//  The state update stage carries all feedback, so one stage sets the rate.
//  Reset is synchronous and returns registers and monitor state to defaults.
//  A stall on status backs up stage by stage; bubbles are squeezed out first.
//
module battery_low_voltage_monitor_top #(
  parameter int SAMPLES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  blvm_pkg::sample_t             sample,
  output logic                          status_valid,
  input  logic                          status_stall,
  output blvm_pkg::status_t             status,
  input  logic                          cfg_write,
  input  logic [blvm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [blvm_pkg::CFG_W-1:0]    cfg_data
);
  import blvm_pkg::*;

  localparam int SLOT_W = $clog2(SAMPLES);
  localparam int SUM_W  = MV_W + $clog2(SAMPLES);
  localparam int THR_W  = SUM_W + 1;
  localparam int RSHIFT = SUM_W + $clog2(SAMPLES);
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RSHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLES - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] sense_gain_q8;
  logic [15:0] low_mv_one_cell;
  logic [15:0] high_mv_one_cell;
  logic [15:0] low_mv_two_cell;
  logic [15:0] high_mv_two_cell;
  logic [15:0] led_period_ms;
  logic [31:0] shutdown_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_gain_q8    <= GAIN_RST;
      low_mv_one_cell  <= LOW_ONE_RST;
      high_mv_one_cell <= HIGH_ONE_RST;
      low_mv_two_cell  <= LOW_TWO_RST;
      high_mv_two_cell <= HIGH_TWO_RST;
      led_period_ms    <= LED_RST;
      shutdown_ms      <= SHUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SENSE_GAIN: sense_gain_q8    <= cfg_data[15:0];
        CFG_LOW_ONE:    low_mv_one_cell  <= cfg_data[15:0];
        CFG_HIGH_ONE:   high_mv_one_cell <= cfg_data[15:0];
        CFG_LOW_TWO:    low_mv_two_cell  <= cfg_data[15:0];
        CFG_HIGH_TWO:   high_mv_two_cell <= cfg_data[15:0];
        CFG_LED_PERIOD: led_period_ms    <= cfg_data[15:0];
        CFG_SHUTDOWN:   shutdown_ms      <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Compare sums instead of averages: floor(sum/N) > t  <=>  sum >= (t+1)*N.
  // Refresh each cycle; users, not the block, keep register changes to idle.
  logic [THR_W-1:0] thr_lo_one, thr_hi_one, thr_lo_two, thr_hi_two;

  always_ff @(posedge clk) begin
    thr_lo_one <= (THR_W'(low_mv_one_cell) + THR_W'(1)) * THR_W'(SAMPLES);
    thr_hi_one <= (THR_W'(high_mv_one_cell) + THR_W'(1)) * THR_W'(SAMPLES);
    thr_lo_two <= (THR_W'(low_mv_two_cell) + THR_W'(1)) * THR_W'(SAMPLES);
    thr_hi_two <= (THR_W'(high_mv_two_cell) + THR_W'(1)) * THR_W'(SAMPLES);
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: each stage takes new data when it is empty or when
  // the stage after it moves.
  // --------------------------------------------------------------------------
  logic a_v, b_v, c_v;
  logic o_rdy, c_rdy, b_rdy, a_rdy;
  logic b_fire;

  assign o_rdy        = !status_valid || !status_stall;
  assign c_rdy        = !c_v || o_rdy;
  assign b_rdy        = !b_v || c_rdy;
  assign a_rdy        = !a_v || b_rdy;
  assign sample_stall = !a_rdy;
  assign b_fire       = b_v && c_rdy;

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  logic [ADC_W-1:0]  a_adc;
  logic [TIME_W-1:0] a_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_rdy) begin
      a_v <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_adc <= sample.sample_adc;
      a_now <= sample.now_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B input: scale to millivolts, floor, saturate at full scale
  // --------------------------------------------------------------------------
  logic [ADC_W+15:0] scale_prod;
  logic [MV_W-1:0]   scale_mv;
  logic [MV_W-1:0]   b_mv;
  logic [TIME_W-1:0] b_now;

  assign scale_prod = (ADC_W+16)'(a_adc) * (ADC_W+16)'(sense_gain_q8);
  assign scale_mv   = (|scale_prod[ADC_W+15:MV_W+8]) ? {MV_W{1'b1}}
                                                     : scale_prod[MV_W+7:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_rdy) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_mv  <= scale_mv;
      b_now <= a_now;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: monitor state
  // --------------------------------------------------------------------------
  logic [MV_W-1:0]   ring [SAMPLES];
  logic [MV_W-1:0]   ring_q;        // prefetched old value of write_slot
  logic              filled;        // ring has wrapped at least once
  logic [SUM_W-1:0]  running_sum;
  logic [SLOT_W-1:0] write_slot;
  logic              low_flag;
  cell_t             cell_count;
  logic [TIME_W-1:0] last_power_time;
  logic [TIME_W-1:0] last_led_time;
  logic              led_state;
  logic [SUM_W-1:0]  sum_hold;      // sum behind the held average
  logic              halted;

  logic              filled_next;
  logic [SUM_W-1:0]  running_sum_next;
  logic [SLOT_W-1:0] write_slot_next;
  logic              low_flag_next;
  cell_t             cell_count_next;
  logic [TIME_W-1:0] last_power_time_next;
  logic [TIME_W-1:0] last_led_time_next;
  logic              led_state_next;
  logic [SUM_W-1:0]  sum_hold_next;
  logic              halted_next;

  logic              first;
  cell_t             cell_eff;
  logic [MV_W-1:0]   old_mv;
  logic              wrapped;
  logic [TIME_W-1:0] power_ref;
  logic [THR_W-1:0]  thr_lo, thr_hi;
  logic              above_lo, above_hi;
  logic              led_due, power_lost;

  logic              c_low, c_low_next;
  logic              c_led, c_led_next;
  logic              c_pd,  c_pd_next;
  logic [SUM_W-1:0]  c_sum;

  assign first     = (cell_count == CELLS_UNKNOWN);
  assign cell_eff  = !first ? cell_count
                   : (b_mv >= TWO_CELL_MV) ? CELLS_TWO : CELLS_ONE;
  assign old_mv    = filled ? ring_q : '0;
  assign wrapped   = (write_slot == LAST_SLOT);
  assign power_ref = first ? b_now : last_power_time;
  assign thr_lo    = (cell_eff == CELLS_TWO) ? thr_lo_two : thr_lo_one;
  assign thr_hi    = (cell_eff == CELLS_TWO) ? thr_hi_two : thr_hi_one;

  assign running_sum_next = running_sum - SUM_W'(old_mv) + SUM_W'(b_mv);
  assign above_lo   = {1'b0, running_sum_next} >= thr_lo;
  assign above_hi   = {1'b0, running_sum_next} >= thr_hi;
  assign led_due    = (b_now - last_led_time) > {16'd0, led_period_ms};
  assign power_lost = (b_now - power_ref) > shutdown_ms;

  always_comb begin
    filled_next          = filled | wrapped;
    write_slot_next      = wrapped ? '0 : write_slot + SLOT_W'(1);
    cell_count_next      = cell_eff;
    last_power_time_next = power_ref;
    low_flag_next        = low_flag;
    last_led_time_next   = last_led_time;
    led_state_next       = led_state;
    sum_hold_next        = sum_hold;
    halted_next          = halted;
    c_low_next           = 1'b0;
    c_led_next           = led_state;
    c_pd_next            = 1'b0;

    if (halted) begin
      // report the latched shutdown, change nothing
      c_low_next = 1'b1;
      c_led_next = 1'b0;
      c_pd_next  = 1'b1;
    end else if (low_flag || wrapped) begin
      sum_hold_next = running_sum_next;
      if (above_lo && !low_flag) begin
        last_power_time_next = b_now;
      end else if (above_hi) begin
        last_power_time_next = b_now;
        low_flag_next        = 1'b0;
      end else begin
        low_flag_next = 1'b1;
        if (led_due) begin
          led_state_next     = !led_state;
          last_led_time_next = b_now;
        end
        c_low_next = 1'b1;
        c_led_next = led_state_next;
        if (power_lost) begin
          halted_next = 1'b1;
          c_led_next  = 1'b0;
          c_pd_next   = 1'b1;
        end
      end
    end
  end

  // Write the new sample and prefetch the next slot's old value together.
  always_ff @(posedge clk) begin
    if (b_fire && !halted) begin
      ring[write_slot] <= b_mv;
      ring_q           <= ring[write_slot_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled          <= 1'b0;
      running_sum     <= '0;
      write_slot      <= '0;
      low_flag        <= 1'b0;
      cell_count      <= CELLS_UNKNOWN;
      last_power_time <= '0;
      last_led_time   <= '0;
      led_state       <= 1'b0;
      sum_hold        <= '0;
      halted          <= 1'b0;
    end else if (b_fire && !halted) begin
      filled          <= filled_next;
      running_sum     <= running_sum_next;
      write_slot      <= write_slot_next;
      low_flag        <= low_flag_next;
      cell_count      <= cell_count_next;
      last_power_time <= last_power_time_next;
      last_led_time   <= last_led_time_next;
      led_state       <= led_state_next;
      sum_hold        <= sum_hold_next;
      halted          <= halted_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_rdy) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_low <= c_low_next;
      c_led <= c_led_next;
      c_pd  <= c_pd_next;
      c_sum <= sum_hold_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output: divide the held sum by SAMPLES with a reciprocal multiply
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] avg_prod;

  assign avg_prod = PROD_W'(c_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (o_rdy) begin
      status_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      status.undervolt  <= c_low;
      status.average_mv <= avg_prod[RSHIFT +: MV_W];
      status.led_level  <= c_led;
      status.power_down <= c_pd;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_halt_sticky : assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted dropped without reset");

  a_pd_halted : assert property (@(posedge clk) disable iff (rst)
    (c_v && c_pd) |-> halted)
    else $error("power-down result without latched halt");

  a_slot_range : assert property (@(posedge clk) disable iff (rst)
    write_slot <= LAST_SLOT)
    else $error("write slot beyond ring");

  a_fresh_ring : assert property (@(posedge clk) disable iff (rst)
    (cell_count == CELLS_UNKNOWN) |-> (write_slot == '0 && !filled && !low_flag))
    else $error("ring advanced before cell detection");

endmodule

// ===== test/tb_battery_low_voltage_monitor_top.sv =====
// ----------------------------------------------------------------------------
// tb_battery_low_voltage_monitor_top: self-checking bench for the monitor
// Streams converter samples into the monitor and checks every status against
// a cycle-free model of the ring average, hysteresis, LED and shutdown logic.
// Covers directed power-up and register cases, randomized level bursts under
// several register settings and idle patterns, back-pressure and power-down.
// ----------------------------------------------------------------------------
module tb_battery_low_voltage_monitor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blvm_pkg::*;

  localparam int SAMPLES        = 8;
  localparam int LATENCY        = 4;
  localparam int QUIET_LIMIT    = 2000;
  localparam int ERROR_PRINTS   = 100;
  localparam int PHASE_SAMPLES  = 240;
  localparam logic [CIDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam logic [31:0] NEVER_SHUT = 32'hFFFF_FFFF;

  // ---------------------------------------------------------------- signals
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              sample_valid = 1'b0;
  logic              sample_stall;
  sample_t           sample_item  = '0;
  logic              status_valid;
  logic              status_stall = 1'b0;
  status_t           status_item;
  logic              cfg_write    = 1'b0;
  logic [CIDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]  cfg_data     = '0;

  battery_low_voltage_monitor_top #(
    .SAMPLES (SAMPLES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_item),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------ model state
  // Register copies, held at the widths the block uses.
  logic [15:0] gain_q8      = GAIN_RST;
  logic [15:0] low_one      = LOW_ONE_RST;
  logic [15:0] high_one     = HIGH_ONE_RST;
  logic [15:0] low_two      = LOW_TWO_RST;
  logic [15:0] high_two     = HIGH_TWO_RST;
  logic [15:0] led_period   = LED_RST;
  logic [31:0] shutdown_lim = SHUT_RST;

  // Monitor state as it stands after reset.
  logic [15:0] ring [SAMPLES] = '{default: '0};
  logic [18:0] ring_sum       = '0;
  int unsigned ring_slot      = 0;
  logic        flagged_low    = 1'b0;
  cell_t       cells          = CELLS_UNKNOWN;
  logic [31:0] power_ok_ms    = '0;
  logic [31:0] led_flip_ms    = '0;
  logic        led_on         = 1'b0;
  logic [15:0] held_avg       = '0;
  logic        shut_off       = 1'b0;

  status_t pending_status [$];
  status_t next_status;

  // ------------------------------------------------------------ bench state
  int          send_idle_pct   = 0;
  int          recv_idle_pct   = 0;
  int          hold_left       = 0;
  int          quiet_cycles    = 0;
  int          mismatches      = 0;
  int          samples_sent    = 0;
  int          results_checked = 0;
  int          low_results     = 0;
  int          shutdown_results = 0;
  int          settings_loaded = 0;
  logic [31:0] clock_ms        = '0;

  // ---------------------------------------------------------------- model
  // Advance the monitor by one sample and return the status it reports.
  function automatic status_t monitor_step(input sample_t item);
    logic [25:0] scaled;
    logic [15:0] mv;
    logic [15:0] avg;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] since_led;
    logic [31:0] since_power;
    logic        wrapped;
    // Once latched, the block ignores everything and reports shutdown.
    if (shut_off)
      return '{1'b1, held_avg, 1'b0, 1'b1};
    // Q8.8 scaling, floored, saturated to 16 bits.
    scaled = item.sample_adc * gain_q8;
    mv = (scaled[25:24] != 2'b00) ? 16'hFFFF : scaled[23:8];
    ring_sum = ring_sum - ring[ring_slot] + mv;
    ring[ring_slot] = mv;
    // The very first sample decides the pack size and starts the power clock.
    if (cells == CELLS_UNKNOWN) begin
      cells = (mv >= TWO_CELL_MV) ? CELLS_TWO : CELLS_ONE;
      power_ok_ms = item.now_ms;
    end
    wrapped = (ring_slot == SAMPLES - 1);
    ring_slot = wrapped ? 0 : ring_slot + 1;
    // Healthy and mid-ring: no check, report the held average.
    if (!flagged_low && !wrapped)
      return '{1'b0, held_avg, led_on, 1'b0};
    avg = 16'(ring_sum / SAMPLES);
    held_avg = avg;
    lo = (cells == CELLS_TWO) ? low_two : low_one;
    hi = (cells == CELLS_TWO) ? high_two : high_one;
    if (avg > lo && !flagged_low) begin
      power_ok_ms = item.now_ms;
      return '{1'b0, held_avg, led_on, 1'b0};
    end
    // Clearing the flag leaves the LED where it is.
    if (avg > hi) begin
      power_ok_ms = item.now_ms;
      flagged_low = 1'b0;
      return '{1'b0, held_avg, led_on, 1'b0};
    end
    flagged_low = 1'b1;
    // Elapsed times wrap modulo 2^32.
    since_led = item.now_ms - led_flip_ms;
    if (since_led > 32'(led_period)) begin
      led_on = !led_on;
      led_flip_ms = item.now_ms;
    end
    since_power = item.now_ms - power_ok_ms;
    if (since_power > shutdown_lim) begin
      shut_off = 1'b1;
      return '{1'b1, held_avg, 1'b0, 1'b1};
    end
    return '{1'b1, held_avg, led_on, 1'b0};
  endfunction

  // ---------------------------------------------------------------- driving
  // Offer one sample; predict its status once the block takes it.
  // Valid stays high on return so back-to-back samples need no extra edge.
  task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TIME_W-1:0] now);
    sample_t item;
    item.sample_adc = adc;
    item.now_ms     = now;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= item;
    @(posedge clk);
    while (sample_stall)
      @(posedge clk);
    pending_status.push_back(monitor_step(item));
    samples_sent++;
  endtask

  // Drop valid and hold until every predicted status has come back.
  task automatic wait_status_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0)
      @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after a batch.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_SENSE_GAIN: gain_q8      = data[15:0];
      CFG_LOW_ONE:    low_one      = data[15:0];
      CFG_HIGH_ONE:   high_one     = data[15:0];
      CFG_LOW_TWO:    low_two      = data[15:0];
      CFG_HIGH_TWO:   high_two     = data[15:0];
      CFG_LED_PERIOD: led_period   = data[15:0];
      CFG_SHUTDOWN:   shutdown_lim = data;
      default: ;
    endcase
  endtask

  // Program every register; junk in the upper half of the 16-bit ones
  // checks that the block drops it.
  task automatic load_settings(input logic [15:0] gain, input logic [15:0] lo1,
                               input logic [15:0] hi1, input logic [15:0] lo2,
                               input logic [15:0] hi2, input logic [15:0] led,
                               input logic [31:0] shut);
    write_reg(CFG_SENSE_GAIN, {16'($urandom), gain});
    write_reg(CFG_LOW_ONE,    {16'($urandom), lo1});
    write_reg(CFG_HIGH_ONE,   {16'($urandom), hi1});
    write_reg(CFG_LOW_TWO,    {16'($urandom), lo2});
    write_reg(CFG_HIGH_TWO,   {16'($urandom), hi2});
    write_reg(CFG_LED_PERIOD, {16'($urandom), led});
    write_reg(CFG_SHUTDOWN,   shut);
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  // Bursts of samples around a random level with time moving forward, so the
  // ring fills with a coherent average; one burst in ten is pure noise with
  // arbitrary timestamps. Now and then pause until the pipe runs dry.
  task automatic run_bursts(input int count);
    int left;
    int len;
    int base;
    int level;
    bit noisy;
    left = count;
    while (left > 0) begin
      len   = $urandom_range(4, 24);
      base  = $urandom_range(0, 1023);
      noisy = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 15) == 0)
        wait_status_drained();
      for (int i = 0; i < len && left > 0; i++) begin
        if (noisy) begin
          clock_ms = $urandom;
          send_sample(10'($urandom_range(0, 1023)), clock_ms);
        end else begin
          level = base + int'($urandom_range(0, 64)) - 32;
          if (level < 0)
            level = 0;
          if (level > 1023)
            level = 1023;
          clock_ms += $urandom_range(0, 120);
          send_sample(10'(level), clock_ms);
        end
        left--;
      end
    end
  endtask

  // ------------------------------------------------------------------ tests
  // Defaults after reset: first sample picks the pack size, a run of zeros
  // drives the flag low and blinks the LED, full scale clears it again.
  // Time starts just below the wrap point and crosses zero.
  task automatic test_power_up_defaults();
    clock_ms = 32'hFFFF_FF00;
    send_sample(10'($urandom_range(0, 1023)), clock_ms);
    for (int i = 0; i < 7; i++) begin
      clock_ms += 10;
      send_sample('0, clock_ms);
    end
    for (int i = 0; i < 4; i++) begin
      clock_ms += 40;
      send_sample('0, clock_ms);
    end
    for (int i = 0; i < 8; i++) begin
      clock_ms += 40;
      send_sample(10'h3FF, clock_ms);
    end
    wait_status_drained();
  endtask

  // Write to an index past the last register, then extreme register values:
  // full gain saturates, timestamps hit both ends of their range.
  task automatic test_register_writes();
    write_reg(CFG_IDX_UNUSED, $urandom);
    load_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, NEVER_SHUT);
    send_sample(10'h3FF, 32'hFFFF_FFFF);
    send_sample(10'h000, 32'h0000_0000);
    send_sample(10'h3FF, 32'h0000_0001);
    send_sample(10'h200, 32'h8000_0000);
    send_sample(10'h001, 32'h7FFF_FFFF);
    send_sample(10'h3FF, 32'h0000_0004);
    wait_status_drained();
    clock_ms = 32'h0000_0010;
  endtask

  // Random level bursts under a series of register settings and idle mixes.
  // Shutdown stays disabled here so the block never halts mid-run.
  task automatic test_random_levels();
    logic [15:0] gain;
    logic [15:0] lo1;
    logic [15:0] hi1;
    logic [15:0] lo2;
    logic [15:0] hi2;
    int          top_mv;
    for (int phase = 0; phase < 6; phase++) begin
      wait_status_drained();
      // Both idle, receiver more, then sender more, then neither idles.
      case (phase / 2)
        0: begin send_idle_pct = 32; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: load_settings(GAIN_RST, LOW_ONE_RST, HIGH_ONE_RST, LOW_TWO_RST, HIGH_TWO_RST,
                         LED_RST, NEVER_SHUT);
        // Full gain: most levels saturate, low ones still trip the flag.
        1: load_settings(16'hFFFF, 16'd60000, 16'd65000, 16'd60000, 16'd65000,
                         16'hFFFF, NEVER_SHUT);
        // Zero gain with zero thresholds: every check lands on the low side.
        2: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                         16'h0000, NEVER_SHUT);
        default: begin
          gain   = 16'($urandom_range(256, 4096));
          top_mv = (int'(gain) * 1023) >> 8;
          lo1 = 16'($urandom_range(0, top_mv));
          lo2 = 16'($urandom_range(0, top_mv));
          hi1 = 16'(lo1 + $urandom_range(0, top_mv / 4));
          hi2 = 16'(lo2 + $urandom_range(0, top_mv / 4));
          // Inverted hysteresis band on one phase.
          if (phase == 4)
            load_settings(gain, hi1, lo1, hi2, lo2, 16'($urandom_range(0, 300)), NEVER_SHUT);
          else
            load_settings(gain, lo1, hi1, lo2, hi2, 16'($urandom_range(0, 300)), NEVER_SHUT);
        end
      endcase
      run_bursts(PHASE_SAMPLES);
    end
    wait_status_drained();
  endtask

  // Hold the status side for a long stretch while samples keep coming, so
  // the pipe fills and stalls its input; drain, rerun with random stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left <= 60;
    run_bursts(40);
    wait_status_drained();
    recv_idle_pct = 46;
    run_bursts(40);
    wait_status_drained();
  endtask

  // Zero gain and zero shutdown time: the next low check latches power-down,
  // after which every sample is ignored. This has to run last.
  task automatic test_power_down();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    load_settings(16'h0000, LOW_ONE_RST, HIGH_ONE_RST, LOW_TWO_RST, HIGH_TWO_RST,
                  16'h0000, 32'h0000_0000);
    for (int i = 0; i < 16; i++) begin
      clock_ms += 3;
      send_sample(10'($urandom_range(0, 1023)), clock_ms);
    end
    wait_status_drained();
  endtask

  // ------------------------------------------------------------ status side
  // Random stall, overridden by a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      status_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else begin
      status_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ERROR_PRINTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Compare each accepted status transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && status_valid && !status_stall) begin
      results_checked++;
      if (status_item.undervolt === 1'b1)
        low_results++;
      if (status_item.power_down === 1'b1)
        shutdown_results++;
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= ERROR_PRINTS)
          $error("status transaction %h arrived with nothing expected", status_item);
      end else begin
        next_status = pending_status.pop_front();
        check_field("undervolt",  32'(next_status.undervolt),  32'(status_item.undervolt));
        check_field("average_mv", 32'(next_status.average_mv), 32'(status_item.average_mv));
        check_field("led_level",  32'(next_status.led_level),  32'(status_item.led_level));
        check_field("power_down", 32'(next_status.power_down), 32'(status_item.power_down));
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (status_valid && !status_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles, %0d status still expected",
             quiet_cycles, pending_status.size());
      $display("battery_low_voltage_monitor_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------- main
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_power_up_defaults();
    test_register_writes();
    test_random_levels();
    test_backpressure();
    test_power_down();

    // Let any stray status show up before the verdict.
    wait_status_drained();
    repeat (4 * LATENCY) @(posedge clk);

    $display("run covered %0d samples, %0d status transactions, %0d register settings",
             samples_sent, results_checked, settings_loaded);
    $display("low battery reported %0d times, power-down reported %0d times",
             low_results, shutdown_results);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("battery_low_voltage_monitor_top: match");
    end else begin
      $display("battery_low_voltage_monitor_top: mismatch");
    end
    $finish;
  end

endmodule
